// ===== sv/esfr_pkg.sv =====
// ----------------------------------------------------------------------------
// esfr_pkg
// Types and constants shared by the escaped serial frame receiver.
// ----------------------------------------------------------------------------
package esfr_pkg;

    // item kinds on the input side
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // result kinds on the output side
    localparam logic RES_PAYLOAD = 1'b0;
    localparam logic RES_STATUS  = 1'b1;

    // configuration register indexes
    localparam logic CFG_START_OPTIONAL = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS  = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

    // framing bytes
    localparam logic [7:0] BYTE_START  = 8'd255;
    localparam logic [7:0] BYTE_END    = 8'd254;
    localparam logic [7:0] BYTE_IGNORE = 8'd253;
    localparam logic [7:0] IGNORE_LOW  = 8'd210;
    localparam logic [7:0] IGNORE_HIGH = 8'd224;
    localparam logic [7:0] ESC_LOW     = 8'd200;
    localparam logic [7:0] ESC_MAX     = 8'd55;
    localparam logic [7:0] ESC_ADD     = 8'd200;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_ESC_RANGE = 3'd2,
        ST_START     = 3'd3,
        ST_END       = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

    typedef struct packed {
        logic        frame_started;
        logic        escape_pending;
        logic [15:0] silence_ticks;
    } rx_state_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        status_t     frame_status;
        logic [6:0]  payload_length;
    } rx_result_t;

endpackage

// ===== sv/esfr_decode.sv =====
// ----------------------------------------------------------------------------
// esfr_decode
// Next-state and result logic for one byte or tick of the framing decoder.
// ----------------------------------------------------------------------------
module esfr_decode import esfr_pkg::*; #(
    parameter int MAX_PAYLOAD = 64,
    parameter int CNT_W       = 7
) (
    input  logic             kind,
    input  logic [7:0]       byte_value,
    input  logic             start_optional,
    input  logic [15:0]      timeout_ticks,
    input  rx_state_t        cur,
    input  logic [CNT_W-1:0] cnt,
    output rx_state_t        nxt,
    output logic [CNT_W-1:0] nxt_cnt,
    output logic             has_result,
    output rx_result_t       res
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

    logic [CNT_W+7:0] cnt_ext;
    logic [CNT_W+7:0] max_ext;
    logic [15:0]      sil_inc;
    logic             do_status;
    logic             do_pay;
    status_t          status;
    logic [6:0]       status_len;
    logic [7:0]       pay_val;
    logic             is_ignored;

    assign cnt_ext    = {8'd0, cnt};
    assign max_ext    = {8'd0, MAX_CNT};
    assign sil_inc    = (cur.silence_ticks != SILENCE_MAX) ? cur.silence_ticks + 16'd1
                                                            : cur.silence_ticks;
    assign is_ignored = (byte_value == BYTE_IGNORE) ||
                        (byte_value >= IGNORE_LOW && byte_value <= IGNORE_HIGH);

    always_comb begin
        nxt        = cur;
        nxt_cnt    = cnt;
        has_result = 1'b0;
        res        = '0;
        do_status  = 1'b0;
        do_pay     = 1'b0;
        status     = ST_OK;
        status_len = cnt_ext[6:0];
        pay_val    = '0;

        if (kind == KIND_TICK) begin
            nxt.silence_ticks = sil_inc;
            if (sil_inc >= timeout_ticks) begin
                do_status = 1'b1;
                status    = ST_TIMEOUT;
            end
        end else begin
            nxt.silence_ticks = '0;
            // escaped byte is checked before any framing rule
            priority if (cur.escape_pending) begin
                if (byte_value > ESC_MAX) begin
                    do_status = 1'b1;
                    status    = ST_ESC_RANGE;
                end else begin
                    nxt.escape_pending = 1'b0;
                    do_pay             = 1'b1;
                    pay_val            = byte_value + ESC_ADD;
                end
            end else if (is_ignored) begin
                nxt.escape_pending = cur.escape_pending;
            end else if (byte_value == BYTE_START) begin
                if (cur.frame_started) begin
                    do_status = 1'b1;
                    status    = ST_START;
                end else begin
                    nxt.frame_started = 1'b1;
                end
            end else if (byte_value == BYTE_END) begin
                do_status = 1'b1;
                status    = cur.frame_started ? ST_OK : ST_END;
            end else if (byte_value >= ESC_LOW) begin
                nxt.escape_pending = 1'b1;
            end else begin
                do_pay  = 1'b1;
                pay_val = byte_value;
            end
        end

        if (do_pay) begin
            if (cnt >= MAX_CNT) begin
                do_status  = 1'b1;
                status     = ST_OVERFLOW;
                status_len = max_ext[6:0];
            end else begin
                has_result        = 1'b1;
                res.result_kind   = RES_PAYLOAD;
                res.payload_byte  = pay_val;
                res.payload_index = cnt_ext[5:0];
                nxt_cnt           = CNT_W'(cnt + 1'b1);
            end
        end

        // every status restarts the frame
        if (do_status) begin
            has_result         = 1'b1;
            res.result_kind    = RES_STATUS;
            res.frame_status   = status;
            res.payload_length = status_len;
            nxt.frame_started  = start_optional;
            nxt.escape_pending = 1'b0;
            nxt.silence_ticks  = '0;
            nxt_cnt            = '0;
        end
    end

endmodule

// ===== sv/escaped_serial_frame_receiver.sv =====
// A result is registered in out_reg, or in skid_reg while out_reg is stalled.
// Throughput: one byte or tick beat per cycle while s_tready is high; decode is a
// single pass of flag and count logic between the state registers and the output
// register. A two-entry output buffer keeps s_tready high while one result is
// stalled. Reset (aresetn low, synchronous) clears the frame state and output
// buffer and loads start_optional = 0, timeout_ticks = 1000.
// ----------------------------------------------------------------------------
// escaped_serial_frame_receiver
// Byte-stuffed serial frame decoder with tick-based silence timeout.
// ----------------------------------------------------------------------------
module escaped_serial_frame_receiver import esfr_pkg::*; #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [15:0] cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tuser,   // kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // payload_byte, payload_index, frame_status, payload_length
    output logic        m_tuser    // result_kind
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    logic             start_optional_reg;
    logic [15:0]      timeout_ticks_reg;
    rx_state_t        state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             has_result;
    rx_result_t       dec_res;

    logic             out_valid_reg, out_valid_next;
    rx_result_t       out_reg, out_next;
    logic             skid_valid_reg, skid_valid_next;
    rx_result_t       skid_reg, skid_next;

    logic             s_accept;
    logic             push;
    logic             pop;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign push     = s_accept && has_result;
    assign pop      = out_valid_reg && m_tready;

    esfr_decode #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CNT_W       (CNT_W)
    ) u_decode (
        .kind           (s_tuser),
        .byte_value     (s_tdata),
        .start_optional (start_optional_reg),
        .timeout_ticks  (timeout_ticks_reg),
        .cur            (state_reg),
        .cnt            (cnt_reg),
        .nxt            (state_next),
        .nxt_cnt        (cnt_next),
        .has_result     (has_result),
        .res            (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_optional_reg <= 1'b0;
            timeout_ticks_reg  <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_START_OPTIONAL: start_optional_reg <= cfg_wr_data[0];
                CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_wr_data;
                default:            start_optional_reg <= start_optional_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            cnt_reg   <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // two-entry output buffer: out_reg faces the port, skid_reg catches a
    // result that arrives while out_reg is stalled
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = dec_res;
            end else begin
                out_valid_next = push;
                out_next       = dec_res;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = dec_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.result_kind;
    assign m_tdata  = {out_reg.payload_length, out_reg.frame_status,
                       out_reg.payload_index, out_reg.payload_byte};

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with output register empty");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond maximum");

    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == KIND_BYTE && s_tdata == BYTE_END &&
         !state_reg.escape_pending)
        |=> (cnt_reg == '0 && !state_reg.escape_pending && out_valid_reg))
        else $error("end byte did not restart the frame with a status");

endmodule
